// ===== design/glu_pkg.sv =====
package glu_pkg;

  // Field widths fixed by the channel payloads
  localparam int unsigned FieldW  = 16;
  localparam int unsigned ResultW = 32;

  // Request payload
  typedef struct packed {
    logic              mode;
    logic [FieldW-1:0] first_operand;
    logic [FieldW-1:0] second_operand;
  } in_t;

  // Result payload
  typedef struct packed {
    logic [ResultW-1:0] result_value;
    logic               error_flag;
  } out_t;

  // Operation codes carried by the mode field
  localparam logic ModeGcd = 1'b0;
  localparam logic ModeLcm = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic err_in;
    logic mode;
    logic gcd_done;
    logic div_done;
  } status_t;

endpackage

// ===== design/glu_ctrl.sv =====
module glu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  glu_pkg::status_t status_i,
  output glu_pkg::cmd_t    cmd_o
);

  glu_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= glu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence one request: gcd, then divide and multiply for lcm; errors skip to finish
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      glu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.err_in ? glu_pkg::ST_FINISH : glu_pkg::ST_GCD;
        end
      end
      glu_pkg::ST_GCD: begin
        if (status_i.gcd_done) begin
          if (status_i.mode == glu_pkg::ModeLcm) begin
            cmd_o.div_init = 1'b1;
            state_d        = glu_pkg::ST_DIV;
          end else begin
            state_d = glu_pkg::ST_FINISH;
          end
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      glu_pkg::ST_DIV: begin
        if (status_i.div_done) begin
          state_d = glu_pkg::ST_MUL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      glu_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = glu_pkg::ST_FINISH;
      end
      glu_pkg::ST_FINISH: begin
        // Wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = glu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glu_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/glu_dp.sv =====
module glu_dp #(
  parameter int unsigned OpW = 16
) (
  input  logic             clk_i,
  input  glu_pkg::in_t     in_data_i,
  input  glu_pkg::cmd_t    cmd_i,
  output glu_pkg::status_t status_o,
  output glu_pkg::out_t    out_data_o
);

  localparam int unsigned CntW = $clog2(OpW + 1);
  localparam int unsigned ProdW = 2 * OpW;

  logic [OpW-1:0] in_x, in_y;
  logic           mode_q;
  logic           err_q;
  logic [OpW-1:0] x_q, y_q;
  logic [OpW-1:0] a_q, a_d, b_q, b_d;
  logic [CntW-1:0] k_q, k_d;
  logic [OpW-1:0] rem_q, rem_d;
  logic [OpW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0] prod_q;
  glu_pkg::out_t  out_q;

  logic [OpW-1:0] gcd_w;
  logic [OpW:0]   trial;
  logic [OpW:0]   diff;

  // Take the operand bits that the width covers
  assign in_x = in_data_i.first_operand[OpW-1:0];
  assign in_y = in_data_i.second_operand[OpW-1:0];

  assign gcd_w = (a_q | b_q) << k_q;

  // Binary gcd step: strip common twos, then halve or subtract odd values
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load) begin
      a_d = in_x;
      b_d = in_y;
      k_d = '0;
    end else if (cmd_i.gcd_step) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + 1'b1;
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = (a_q - b_q) >> 1;
      end else begin
        b_d = (b_q - a_q) >> 1;
      end
    end
  end

  // Restoring division of the first operand by the gcd, one bit a cycle
  assign trial = {rem_q, quo_q[OpW-1]};
  assign diff  = trial - {1'b0, gcd_w};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (cmd_i.div_init) begin
      rem_d = '0;
      quo_d = x_q;
      cnt_d = CntW'(OpW);
    end else if (cmd_i.div_step) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[OpW]) begin
        rem_d = diff[OpW-1:0];
        quo_d = {quo_q[OpW-2:0], 1'b1};
      end else begin
        rem_d = trial[OpW-1:0];
        quo_d = {quo_q[OpW-2:0], 1'b0};
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_data_i.mode;
      err_q  <= status_o.err_in;
      x_q    <= in_x;
      y_q    <= in_y;
    end
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    if (cmd_i.mul) begin
      prod_q <= ProdW'(quo_q) * ProdW'(y_q);
    end
  end

  // Output register: error forces a zero value
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.error_flag <= err_q;
      if (err_q) begin
        out_q.result_value <= '0;
      end else if (mode_q == glu_pkg::ModeLcm) begin
        out_q.result_value <= glu_pkg::ResultW'(prod_q);
      end else begin
        out_q.result_value <= glu_pkg::ResultW'(gcd_w);
      end
    end
  end

  // Status back to the controller
  always_comb begin
    status_o.err_in = (in_data_i.mode == glu_pkg::ModeLcm)
                      ? ((in_x == '0) || (in_y == '0))
                      : ((in_x == '0) && (in_y == '0));
    status_o.mode     = mode_q;
    status_o.gcd_done = (a_q == '0) || (b_q == '0);
    status_o.div_done = (cnt_q == '0);
  end

  assign out_data_o = out_q;

endmodule

// ===== design/gcd_lcm_unit_core.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   glu_pkg::in_t  (mode, two operands)
// out      output     out_valid_o/out_ready_i glu_pkg::out_t (result, error flag)
//
// One request at a time. Gcd uses the binary method, one shift or subtract per
// cycle; lcm then divides the first operand by the gcd bit-serially and
// multiplies the quotient by the second; operands use min(OPERAND_WIDTH, 16) bits.
// Requests with zero operands that flag an error skip to the finish state.
// Reset clears the controller and the output valid; the datapath needs none.
// A stalled result sits in the output register; the next request is taken
// meanwhile and waits at its end until the register drains.
module gcd_lcm_unit_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  glu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output glu_pkg::out_t out_data_o
);

  localparam int unsigned OpW =
      (OPERAND_WIDTH < glu_pkg::FieldW) ? OPERAND_WIDTH : glu_pkg::FieldW;

  glu_pkg::cmd_t    cmd;
  glu_pkg::status_t status;

  // Sequence control
  glu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic
  glu_dp #(
    .OpW (OpW)
  ) u_dp (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== verif/gcd_lcm_unit_core_tb.sv =====
`timescale 1ns / 1ps

module gcd_lcm_unit_core_tb;

  localparam int unsigned OperandW     = 16;
  localparam int unsigned DirRows      = 20;
  localparam int unsigned RandPerPhase = 375;
  localparam int unsigned TailCycles   = 60;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic                        mode;
    logic [glu_pkg::FieldW-1:0]  first_operand;
    logic [glu_pkg::FieldW-1:0]  second_operand;
    logic                        typed;
    logic [glu_pkg::ResultW-1:0] result_value;
    logic                        error_flag;
  } dir_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  glu_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  glu_pkg::out_t out_data;

  // Side information that travels with the request on the wire
  logic          req_typed = 1'b0;
  glu_pkg::out_t req_typed_exp = '0;

  glu_pkg::out_t expected_results_q[$];
  glu_pkg::out_t oldest_result;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatch_count = 0;
  int   gcd_req_count = 0;
  int   lcm_req_count = 0;
  int   err_req_count = 0;
  int   result_count = 0;

  dir_row_t dir_rows [DirRows];

  gcd_lcm_unit_core #(
    .OPERAND_WIDTH(OperandW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Compute gcd or lcm of one request with Euclid's method
  function automatic glu_pkg::out_t gcd_lcm_expected(input glu_pkg::in_t req);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] rem;
    logic [63:0] g;
    logic [63:0] prod;
    glu_pkg::out_t res;
    mask = (64'd1 << OperandW) - 64'd1;
    x = {48'd0, req.first_operand} & mask;
    y = {48'd0, req.second_operand} & mask;
    res = '0;
    if (req.mode == glu_pkg::ModeGcd) begin
      if (x == 0 && y == 0) begin
        res.error_flag = 1'b1;
        return res;
      end
    end else if (x == 0 || y == 0) begin
      res.error_flag = 1'b1;
      return res;
    end
    g = x;
    rem = y;
    while (rem != 0) begin
      prod = g % rem;
      g = rem;
      rem = prod;
    end
    if (req.mode == glu_pkg::ModeGcd) begin
      res.result_value = g[glu_pkg::ResultW-1:0];
    end else begin
      prod = (x / g) * y;
      if (prod > 64'hFFFF_FFFF) begin
        res.error_flag = 1'b1;
      end else begin
        res.result_value = prod[glu_pkg::ResultW-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Pick an operand, biased toward zero, the maximum, powers of two and small values
  function automatic logic [glu_pkg::FieldW-1:0] rand_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return glu_pkg::FieldW'(1) << $urandom_range(glu_pkg::FieldW - 1);
      3, 4: return glu_pkg::FieldW'($urandom_range(64, 1));
      default: return glu_pkg::FieldW'($urandom());
    endcase
  endfunction

  function automatic glu_pkg::in_t random_req();
    glu_pkg::in_t req;
    int unsigned factor;
    req.mode = $urandom_range(1) ? glu_pkg::ModeLcm : glu_pkg::ModeGcd;
    // Shared factor gives gcds well above one
    if ($urandom_range(9) < 3) begin
      factor = $urandom_range(200, 1);
      req.first_operand = glu_pkg::FieldW'(factor * $urandom_range(320));
      req.second_operand = glu_pkg::FieldW'(factor * $urandom_range(320));
    end else begin
      req.first_operand = rand_operand();
      req.second_operand = rand_operand();
    end
    return req;
  endfunction

  // Hold the request until accepted, idling before it at the phase's rate
  task automatic send_req(input glu_pkg::in_t req, input logic typed,
                          input glu_pkg::out_t typed_exp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    req_typed <= typed;
    req_typed_exp <= typed_exp;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Stall the result channel at the phase's rate
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check results against the oldest expectation, then record new requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with nothing expected",
                                    out_data.result_value, out_data.error_flag));
        end else begin
          oldest_result = expected_results_q.pop_front();
          if (out_data.result_value !== oldest_result.result_value) begin
            report_mismatch($sformatf("result_value %h, expected %h",
                                      out_data.result_value, oldest_result.result_value));
          end
          if (out_data.error_flag !== oldest_result.error_flag) begin
            report_mismatch($sformatf("error_flag %b, expected %b",
                                      out_data.error_flag, oldest_result.error_flag));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.mode == glu_pkg::ModeGcd) gcd_req_count++;
        else lcm_req_count++;
        if (req_typed) begin
          expected_results_q.push_back(req_typed_exp);
        end else begin
          expected_results_q.push_back(gcd_lcm_expected(in_data));
        end
        if (expected_results_q[$].error_flag) err_req_count++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    glu_pkg::out_t row_exp;
    glu_pkg::in_t  req;
    // Zero operands, extremes and a few plain cases
    dir_rows = '{
      '{glu_pkg::ModeGcd, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000, 1'b1},
      '{glu_pkg::ModeLcm, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000, 1'b1},
      '{glu_pkg::ModeLcm, 16'h0000, 16'h1234, 1'b1, 32'h0000_0000, 1'b1},
      '{glu_pkg::ModeLcm, 16'hFFFF, 16'h0000, 1'b1, 32'h0000_0000, 1'b1},
      '{glu_pkg::ModeGcd, 16'h0000, 16'h0007, 1'b1, 32'h0000_0007, 1'b0},
      '{glu_pkg::ModeGcd, 16'hFFFF, 16'h0000, 1'b1, 32'h0000_FFFF, 1'b0},
      '{glu_pkg::ModeGcd, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0000_FFFF, 1'b0},
      '{glu_pkg::ModeLcm, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0000_FFFF, 1'b0},
      '{glu_pkg::ModeGcd, 16'h0001, 16'h0001, 1'b1, 32'h0000_0001, 1'b0},
      '{glu_pkg::ModeLcm, 16'h0001, 16'h0001, 1'b1, 32'h0000_0001, 1'b0},
      '{glu_pkg::ModeLcm, 16'h0001, 16'hFFFF, 1'b1, 32'h0000_FFFF, 1'b0},
      '{glu_pkg::ModeLcm, 16'hFFFF, 16'hFFFE, 1'b1, 32'hFFFD_0002, 1'b0},
      '{glu_pkg::ModeLcm, 16'h8000, 16'h7FFF, 1'b1, 32'h3FFF_8000, 1'b0},
      '{glu_pkg::ModeGcd, 16'h8000, 16'h4000, 1'b1, 32'h0000_4000, 1'b0},
      '{glu_pkg::ModeGcd, 16'h0030, 16'h0012, 1'b0, 32'h0000_0000, 1'b0},
      '{glu_pkg::ModeLcm, 16'h000C, 16'h0012, 1'b0, 32'h0000_0000, 1'b0},
      '{glu_pkg::ModeGcd, 16'hFFFE, 16'h8000, 1'b0, 32'h0000_0000, 1'b0},
      '{glu_pkg::ModeGcd, 16'hAAAA, 16'h5555, 1'b0, 32'h0000_0000, 1'b0},
      '{glu_pkg::ModeLcm, 16'h5555, 16'hAAAA, 1'b0, 32'h0000_0000, 1'b0},
      '{glu_pkg::ModeGcd, 16'h1E0F, 16'h0F1E, 1'b0, 32'h0000_0000, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling
    foreach (dir_rows[i]) begin
      req.mode = dir_rows[i].mode;
      req.first_operand = dir_rows[i].first_operand;
      req.second_operand = dir_rows[i].second_operand;
      row_exp.result_value = dir_rows[i].result_value;
      row_exp.error_flag = dir_rows[i].error_flag;
      send_req(req, dir_rows[i].typed, row_exp);
    end
    drain_results();

    // Random requests over four idle and stall phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        send_req(random_req(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d gcd and %0d lcm requests (%0d flagged as errors),",
             gcd_req_count, lcm_req_count, err_req_count);
    $display("%0d results checked, with directed extremes and random traffic %s",
             result_count, "under sender and receiver pressure.");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
